[design/assert_macros.svh]
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property with reset disable.
`define SMX_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be true.
`define SMX_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SMX_ASSERT(lbl, clk, rstn, prop, msg)
`define SMX_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

[design/smx_pkg.sv]
`default_nettype none
package smx_pkg;

    localparam int DATA_W              = 32;
    localparam int CMD_W               = 4;
    localparam int KIND_W              = 2;
    localparam int STAT_W              = 3;
    localparam int DEFAULT_STACK_DEPTH = 32;
    localparam logic [DATA_W-1:0] CHAR_MAX_CODE = 32'd127;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 4'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SWAP  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DIV   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MUL   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_MOD   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_NOP   = 4'd8;
    localparam logic [CMD_W-1:0] CMD_PINT  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_PALL  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_PCHAR = 4'd11;
    localparam logic [CMD_W-1:0] CMD_PSTR  = 4'd12;
    localparam logic [CMD_W-1:0] CMD_ROTL  = 4'd13;
    localparam logic [CMD_W-1:0] CMD_ROTR  = 4'd14;

    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EOL    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [STAT_W-1:0] ST_SHORT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd5;

    // Read address selects.
    localparam logic [1:0] RD_TOP    = 2'd0;
    localparam logic [1:0] RD_BELOW  = 2'd1;
    localparam logic [1:0] RD_WALK   = 2'd2;
    localparam logic [1:0] RD_BOTTOM = 2'd3;

    // Write address selects.
    localparam logic [1:0] WA_NEXT  = 2'd0;
    localparam logic [1:0] WA_TOP   = 2'd1;
    localparam logic [1:0] WA_BELOW = 2'd2;
    localparam logic [1:0] WA_ROTL  = 2'd3;

    // Write data selects.
    localparam logic [2:0] WD_PUSH  = 3'd0;
    localparam logic [2:0] WD_TOP   = 3'd1;
    localparam logic [2:0] WD_BELOW = 3'd2;
    localparam logic [2:0] WD_ADD   = 3'd3;
    localparam logic [2:0] WD_SUB   = 3'd4;
    localparam logic [2:0] WD_MUL   = 3'd5;
    localparam logic [2:0] WD_QUO   = 3'd6;
    localparam logic [2:0] WD_REM   = 3'd7;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_INC  = 2'd1;
    localparam logic [1:0] OP_DEC  = 2'd2;

    localparam logic [1:0] OV_ZERO  = 2'd0;
    localparam logic [1:0] OV_TOP   = 2'd1;
    localparam logic [1:0] OV_RDATA = 2'd2;

    typedef struct packed {
        logic              load_in;
        logic              rd_en;
        logic [1:0]        rd_sel;
        logic              cap_top;
        logic              cap_below;
        logic              wr_en;
        logic [1:0]        wa_sel;
        logic [2:0]        wd_sel;
        logic [1:0]        cnt_op;
        logic [1:0]        bot_op;
        logic              walk_load;
        logic              walk_dec;
        logic              div_start;
        logic              out_load;
        logic [1:0]        out_sel;
        logic [KIND_W-1:0] out_kind;
        logic [STAT_W-1:0] out_status;
        logic              out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic lt_two;
        logic full;
        logic top_zero;
        logic top_not_char;
        logic rd_not_char;
        logic walk_one;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

[design/smx_div.sv]
`default_nettype none
module smx_div import smx_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic [DATA_W-1:0]      quot,
    output logic [DATA_W-1:0]      rem
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg, done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] q_reg, r_reg, d_reg;
    logic              neg_q_reg, neg_r_reg;
    logic [DATA_W:0]   trial, diff;

    // One quotient bit per cycle, restoring on magnitudes.
    assign trial = {r_reg, q_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(DATA_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg     <= dividend[DATA_W-1] ? -dividend : dividend;
            d_reg     <= divisor[DATA_W-1] ? -divisor : divisor;
            r_reg     <= '0;
            neg_q_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
            neg_r_reg <= dividend[DATA_W-1];
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                r_reg <= diff[DATA_W-1:0];
                q_reg <= {q_reg[DATA_W-2:0], 1'b1};
            end else begin
                r_reg <= trial[DATA_W-1:0];
                q_reg <= {q_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_q_reg ? -q_reg : q_reg;
    assign rem  = neg_r_reg ? -r_reg : r_reg;

endmodule
`default_nettype wire

[design/smx_dpath.sv]
`default_nettype none
module smx_dpath import smx_pkg::*; #(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic signed [DATA_W-1:0] push_value,
    input  wire dp_cmd_t                  cmd,
    output dp_stat_t                      stat,
    input  wire logic                     m_ready,
    output logic                          m_valid,
    output logic signed [DATA_W-1:0]      m_out_value,
    output logic [KIND_W-1:0]             m_out_kind,
    output logic [STAT_W-1:0]             m_status,
    output logic                          m_last
);

    localparam int SLOT_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W:0]    DEPTH_X   = (CNT_W + 1)'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_C   = CNT_W'(STACK_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(STACK_DEPTH - 1);

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  pos);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + {1'b0, pos};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[SLOT_W-1:0];
    endfunction

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg, top_reg, below_reg, pv_reg;
    logic [CNT_W-1:0]  count_reg, walk_reg;
    logic [SLOT_W-1:0] bottom_reg;
    logic              m_valid_reg, m_last_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic [STAT_W-1:0] out_status_reg;

    logic [CNT_W-1:0]  count_m1, count_m2;
    logic [SLOT_W-1:0] bottom_m1, bottom_p1, raddr, waddr;
    logic [DATA_W-1:0] wdata, mul_lo, quot, rem;
    logic              div_done;

    assign count_m1  = count_reg - CNT_W'(1);
    assign count_m2  = count_reg - CNT_W'(2);
    assign bottom_m1 = (bottom_reg == '0) ? LAST_SLOT : bottom_reg - SLOT_W'(1);
    assign bottom_p1 = (bottom_reg == LAST_SLOT) ? '0 : bottom_reg + SLOT_W'(1);
    assign mul_lo    = below_reg * top_reg;

    always_comb begin
        case (cmd.rd_sel)
            RD_TOP:   raddr = slot_of(bottom_reg, count_m1);
            RD_BELOW: raddr = slot_of(bottom_reg, count_m2);
            RD_WALK:  raddr = slot_of(bottom_reg, walk_reg - CNT_W'(1));
            default:  raddr = bottom_reg;
        endcase
        case (cmd.wa_sel)
            WA_NEXT:  waddr = slot_of(bottom_reg, count_reg);
            WA_TOP:   waddr = slot_of(bottom_reg, count_m1);
            WA_BELOW: waddr = slot_of(bottom_reg, count_m2);
            default:  waddr = bottom_m1;
        endcase
        case (cmd.wd_sel)
            WD_PUSH:  wdata = pv_reg;
            WD_TOP:   wdata = top_reg;
            WD_BELOW: wdata = below_reg;
            WD_ADD:   wdata = below_reg + top_reg;
            WD_SUB:   wdata = below_reg - top_reg;
            WD_MUL:   wdata = mul_lo;
            WD_QUO:   wdata = quot;
            default:  wdata = rem;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            pv_reg <= push_value;
        end
        if (cmd.cap_top) begin
            top_reg <= rdata_reg;
        end
        if (cmd.cap_below) begin
            below_reg <= rdata_reg;
        end
        if (cmd.walk_load) begin
            walk_reg <= count_reg;
        end else if (cmd.walk_dec) begin
            walk_reg <= walk_reg - CNT_W'(1);
        end
        if (cmd.out_load) begin
            case (cmd.out_sel)
                OV_TOP:   out_value_reg <= top_reg;
                OV_RDATA: out_value_reg <= rdata_reg;
                default:  out_value_reg <= '0;
            endcase
            out_kind_reg   <= cmd.out_kind;
            out_status_reg <= cmd.out_status;
            m_last_reg     <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            bottom_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (cmd.cnt_op)
                OP_INC:  count_reg <= count_reg + CNT_W'(1);
                OP_DEC:  count_reg <= count_m1;
                default: count_reg <= count_reg;
            endcase
            case (cmd.bot_op)
                OP_INC:  bottom_reg <= bottom_p1;
                OP_DEC:  bottom_reg <= bottom_m1;
                default: bottom_reg <= bottom_reg;
            endcase
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    smx_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (below_reg),
        .divisor  (top_reg),
        .done     (div_done),
        .quot     (quot),
        .rem      (rem)
    );

    always_comb begin
        stat.empty        = (count_reg == '0);
        stat.lt_two       = (count_reg < CNT_W'(2));
        stat.full         = (count_reg >= DEPTH_C);
        stat.top_zero     = (top_reg == '0);
        stat.top_not_char = (top_reg > CHAR_MAX_CODE);
        stat.rd_not_char  = (rdata_reg == '0) || (rdata_reg > CHAR_MAX_CODE);
        stat.walk_one     = (walk_reg == CNT_W'(1));
        stat.div_done     = div_done;
        stat.out_free     = !m_valid_reg || m_ready;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = out_value_reg;
    assign m_out_kind  = out_kind_reg;
    assign m_status    = out_status_reg;
    assign m_last      = m_last_reg;

endmodule
`default_nettype wire

[design/smx_ctrl.sv]
`default_nettype none
module smx_ctrl import smx_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic [CMD_W-1:0] s_cmd,
    output logic                  s_ready,
    input  wire dp_stat_t         stat,
    output dp_cmd_t               cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD_TOP   = 4'd1;
    localparam logic [3:0] S_RD_BELOW = 4'd2;
    localparam logic [3:0] S_CAP      = 4'd3;
    localparam logic [3:0] S_DISPATCH = 4'd4;
    localparam logic [3:0] S_SWAP2    = 4'd5;
    localparam logic [3:0] S_DIV      = 4'd6;
    localparam logic [3:0] S_WALK_RD  = 4'd7;
    localparam logic [3:0] S_WALK_EM  = 4'd8;
    localparam logic [3:0] S_EOL      = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg;
    logic             is_pall;

    assign s_ready = (state_reg == S_IDLE);
    assign is_pall = (cmd_reg == CMD_PALL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_cmd;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_RD_TOP;
                end
            end
            S_RD_TOP: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_TOP;
                state_next = S_RD_BELOW;
            end
            S_RD_BELOW: begin
                cmd.cap_top = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = (cmd_reg == CMD_ROTR) ? RD_BOTTOM : RD_BELOW;
                state_next  = S_CAP;
            end
            S_CAP: begin
                cmd.cap_below = 1'b1;
                state_next    = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (stat.out_free) begin
                    state_next   = S_IDLE;
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    case (cmd_reg)
                        CMD_PUSH: begin
                            if (stat.full) begin
                                cmd.out_status = ST_FULL;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                cmd.wa_sel = WA_NEXT;
                                cmd.wd_sel = WD_PUSH;
                                cmd.cnt_op = OP_INC;
                            end
                        end
                        CMD_POP: begin
                            if (stat.empty) begin
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.cnt_op = OP_DEC;
                            end
                        end
                        CMD_SWAP, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD: begin
                            if (stat.lt_two) begin
                                cmd.out_status = ST_SHORT;
                            end else if ((cmd_reg == CMD_DIV || cmd_reg == CMD_MOD)
                                         && stat.top_zero) begin
                                cmd.out_status = ST_DIVZERO;
                            end else if (cmd_reg == CMD_SWAP) begin
                                cmd.out_load = 1'b0;
                                cmd.wr_en    = 1'b1;
                                cmd.wa_sel   = WA_TOP;
                                cmd.wd_sel   = WD_BELOW;
                                state_next   = S_SWAP2;
                            end else if (cmd_reg == CMD_DIV || cmd_reg == CMD_MOD) begin
                                cmd.out_load  = 1'b0;
                                cmd.div_start = 1'b1;
                                state_next    = S_DIV;
                            end else begin
                                cmd.wr_en  = 1'b1;
                                cmd.wa_sel = WA_BELOW;
                                cmd.cnt_op = OP_DEC;
                                case (cmd_reg)
                                    CMD_ADD: cmd.wd_sel = WD_ADD;
                                    CMD_SUB: cmd.wd_sel = WD_SUB;
                                    default: cmd.wd_sel = WD_MUL;
                                endcase
                            end
                        end
                        CMD_PINT: begin
                            if (stat.empty) begin
                                cmd.out_status = ST_EMPTY;
                            end else begin
                                cmd.out_sel  = OV_TOP;
                                cmd.out_kind = KIND_INT;
                            end
                        end
                        CMD_PCHAR: begin
                            if (stat.empty) begin
                                cmd.out_status = ST_EMPTY;
                            end else if (stat.top_not_char) begin
                                cmd.out_status = ST_RANGE;
                            end else begin
                                cmd.out_sel  = OV_TOP;
                                cmd.out_kind = KIND_CHAR;
                            end
                        end
                        CMD_PALL, CMD_PSTR: begin
                            if (!stat.empty) begin
                                cmd.out_load  = 1'b0;
                                cmd.walk_load = 1'b1;
                                state_next    = S_WALK_RD;
                            end else if (cmd_reg == CMD_PSTR) begin
                                cmd.out_load = 1'b0;
                                state_next   = S_EOL;
                            end
                        end
                        CMD_ROTL: begin
                            if (!stat.lt_two) begin
                                cmd.wr_en  = 1'b1;
                                cmd.wa_sel = WA_ROTL;
                                cmd.wd_sel = WD_TOP;
                                cmd.bot_op = OP_DEC;
                            end
                        end
                        CMD_ROTR: begin
                            // The old bottom lands one past the top, which is the
                            // new top slot once the bottom moves up.
                            if (!stat.lt_two) begin
                                cmd.wr_en  = 1'b1;
                                cmd.wa_sel = WA_NEXT;
                                cmd.wd_sel = WD_BELOW;
                                cmd.bot_op = OP_INC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWAP2: begin
                if (stat.out_free) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wa_sel   = WA_BELOW;
                    cmd.wd_sel   = WD_TOP;
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV: begin
                if (stat.div_done && stat.out_free) begin
                    cmd.wr_en    = 1'b1;
                    cmd.wa_sel   = WA_BELOW;
                    cmd.wd_sel   = (cmd_reg == CMD_DIV) ? WD_QUO : WD_REM;
                    cmd.cnt_op   = OP_DEC;
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_WALK_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_WALK;
                state_next = S_WALK_EM;
            end
            S_WALK_EM: begin
                if (!is_pall && stat.rd_not_char) begin
                    state_next = S_EOL;
                end else if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OV_RDATA;
                    cmd.out_kind = is_pall ? KIND_INT : KIND_CHAR;
                    cmd.out_last = is_pall && stat.walk_one;
                    cmd.walk_dec = 1'b1;
                    if (stat.walk_one) begin
                        state_next = is_pall ? S_IDLE : S_EOL;
                    end else begin
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_EOL: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_EOL;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/stack_machine_execute.sv]
// Stack machine executor. Each input beat on the s_ channel carries one
// command (s_cmd) and, for push, the value (s_push_value). Each command
// produces one or more result beats on the m_ channel; m_last marks the
// final beat of a command. Status-only beats carry a zero value.
// After a beat is accepted, the controller reads the top and a second entry
// (the one below it, or the bottom for rotr) and then decodes the command;
// a simple command loads its single result beat into the output register
// at decode. Div and mod wait in S_DIV for the radix-2 divider to finish.
// Pall and pstr walk the stack from the top down, each entry read through
// the registered read port before it is emitted. One command is in flight
// at a time; s_ready is high only while the block waits for a new command.
// A result beat sits in an output register, so the next command is taken
// while the final beat still waits; if the receiver holds m_ready low, the
// block stalls at its next beat to emit until the register frees.
// Reset (aresetn low, synchronous) empties the stack and drops any beat
// held in the output register; stack memory contents are not cleared.
`default_nettype none
`include "assert_macros.svh"
module stack_machine_execute import smx_pkg::*; #(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [CMD_W-1:0]         s_cmd,
    input  wire logic signed [DATA_W-1:0] s_push_value,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic signed [DATA_W-1:0]      m_out_value,
    output logic [KIND_W-1:0]             m_out_kind,
    output logic [STAT_W-1:0]             m_status,
    output logic                          m_last
);

    // The controller sequences every command; the datapath holds the stack
    // memory, the entry count, the circular bottom pointer and the divider.
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    smx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .stat    (dp_stat),
        .cmd     (dp_cmd)
    );

    smx_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_value  (s_push_value),
        .cmd         (dp_cmd),
        .stat        (dp_stat),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_out_value (m_out_value),
        .m_out_kind  (m_out_kind),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    // A result beat is loaded only into a free output register.
    `SMX_NEVER(a_out_overrun, aclk, aresetn, dp_cmd.out_load && !dp_stat.out_free,
        "result loaded over an untaken beat")
    // The stack is never written while waiting for a command.
    `SMX_NEVER(a_idle_write, aclk, aresetn, s_ready && dp_cmd.wr_en,
        "stack write while idle")
    // A divider start always clears its done flag on the next cycle.
    `SMX_ASSERT(a_div_restart, aclk, aresetn, dp_cmd.div_start |=> !dp_stat.div_done,
        "divider done not cleared by start")

endmodule
`default_nettype wire

[tb/sv/stack_machine_checker.sv]
`timescale 1ns / 100ps
module stack_machine_checker import smx_pkg::*; #(
    parameter int DEPTH = DEFAULT_STACK_DEPTH
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    input  wire logic                     s_ready,
    input  wire logic [CMD_W-1:0]         s_cmd,
    input  wire logic signed [DATA_W-1:0] s_push_value,
    input  wire logic                     m_valid,
    input  wire logic                     m_ready,
    input  wire logic signed [DATA_W-1:0] m_out_value,
    input  wire logic [KIND_W-1:0]        m_out_kind,
    input  wire logic [STAT_W-1:0]        m_status,
    input  wire logic                     m_last,
    output int                            pending,
    output int                            errors
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic              last;
    } beat_t;

    localparam logic [DATA_W-1:0] MIN_INT = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] NEG_ONE = '1;

    beat_t             expected_beats[$];
    logic [DATA_W-1:0] shadow_stack[DEPTH];
    int unsigned       depth_used = 0;
    int unsigned       base_slot = 0;
    int                fail_count = 0;

    assign pending = expected_beats.size();
    assign errors  = fail_count;

    function automatic int unsigned slot(int unsigned pos);
        return (base_slot + pos) % DEPTH;
    endfunction

    task automatic add_beat(logic [DATA_W-1:0] v, logic [KIND_W-1:0] k, logic [STAT_W-1:0] s);
        beat_t b;
        b.value = v;
        b.kind = k;
        b.status = s;
        b.last = 1'b0;
        expected_beats.push_back(b);
    endtask

    // Executes one command on the shadow stack and queues the beats it causes.
    task automatic execute_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] pv);
        logic [DATA_W-1:0]        top, below, res, v;
        logic signed [DATA_W-1:0] sa, sb, quo_s, rem_s;
        int unsigned              i;
        int                       start;
        start = expected_beats.size();
        top = '0;
        below = '0;
        res = '0;
        if (depth_used > 0) top = shadow_stack[slot(depth_used - 1)];
        if (depth_used > 1) below = shadow_stack[slot(depth_used - 2)];
        sa = below;
        sb = top;
        case (cmd)
            CMD_PUSH: begin
                if (depth_used >= DEPTH) begin
                    add_beat('0, KIND_STATUS, ST_FULL);
                end else begin
                    shadow_stack[slot(depth_used)] = pv;
                    depth_used++;
                    add_beat('0, KIND_STATUS, ST_OK);
                end
            end
            CMD_POP: begin
                if (depth_used == 0) begin
                    add_beat('0, KIND_STATUS, ST_EMPTY);
                end else begin
                    depth_used--;
                    add_beat('0, KIND_STATUS, ST_OK);
                end
            end
            CMD_SWAP, CMD_ADD, CMD_SUB, CMD_DIV, CMD_MUL, CMD_MOD: begin
                if (depth_used < 2) begin
                    add_beat('0, KIND_STATUS, ST_SHORT);
                end else if ((cmd == CMD_DIV || cmd == CMD_MOD) && top == '0) begin
                    add_beat('0, KIND_STATUS, ST_DIVZERO);
                end else if (cmd == CMD_SWAP) begin
                    shadow_stack[slot(depth_used - 1)] = below;
                    shadow_stack[slot(depth_used - 2)] = top;
                    add_beat('0, KIND_STATUS, ST_OK);
                end else begin
                    case (cmd)
                        CMD_ADD: res = below + top;
                        CMD_SUB: res = below - top;
                        CMD_MUL: res = below * top;
                        CMD_DIV: begin
                            if (below == MIN_INT && top == NEG_ONE) begin
                                res = MIN_INT;
                            end else begin
                                quo_s = sa / sb;
                                res = quo_s;
                            end
                        end
                        default: begin
                            if (top == NEG_ONE) begin
                                res = '0;
                            end else begin
                                rem_s = sa % sb;
                                res = rem_s;
                            end
                        end
                    endcase
                    depth_used--;
                    shadow_stack[slot(depth_used - 1)] = res;
                    add_beat('0, KIND_STATUS, ST_OK);
                end
            end
            CMD_PINT: begin
                if (depth_used == 0) add_beat('0, KIND_STATUS, ST_EMPTY);
                else add_beat(top, KIND_INT, ST_OK);
            end
            CMD_PALL: begin
                if (depth_used == 0) add_beat('0, KIND_STATUS, ST_OK);
                for (i = depth_used; i > 0; i--)
                    add_beat(shadow_stack[slot(i - 1)], KIND_INT, ST_OK);
            end
            CMD_PCHAR: begin
                if (depth_used == 0) add_beat('0, KIND_STATUS, ST_EMPTY);
                else if (top > CHAR_MAX_CODE) add_beat('0, KIND_STATUS, ST_RANGE);
                else add_beat(top, KIND_CHAR, ST_OK);
            end
            CMD_PSTR: begin
                for (i = depth_used; i > 0; i--) begin
                    v = shadow_stack[slot(i - 1)];
                    if (v == '0 || v > CHAR_MAX_CODE) break;
                    add_beat(v, KIND_CHAR, ST_OK);
                end
                add_beat('0, KIND_EOL, ST_OK);
            end
            CMD_ROTL: begin
                if (depth_used >= 2) begin
                    base_slot = (base_slot + DEPTH - 1) % DEPTH;
                    shadow_stack[base_slot] = top;
                end
                add_beat('0, KIND_STATUS, ST_OK);
            end
            CMD_ROTR: begin
                if (depth_used >= 2) begin
                    v = shadow_stack[base_slot];
                    base_slot = (base_slot + 1) % DEPTH;
                    shadow_stack[slot(depth_used - 1)] = v;
                end
                add_beat('0, KIND_STATUS, ST_OK);
            end
            default: add_beat('0, KIND_STATUS, ST_OK);
        endcase
        if (expected_beats.size() > start) expected_beats[$].last = 1'b1;
    endtask

    always @(posedge aclk) begin
        beat_t exp_beat;
        beat_t got;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_out_value, m_out_kind, m_status, m_last};
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, got);
                    fail_count++;
                end else begin
                    exp_beat = expected_beats.pop_front();
                    if (got.value !== exp_beat.value) begin
                        $display("%0t: out_value expected %0d actual %0d", $time,
                                 $signed(exp_beat.value), $signed(got.value));
                        fail_count++;
                    end
                    if (got.kind !== exp_beat.kind) begin
                        $display("%0t: out_kind expected %0d actual %0d", $time,
                                 exp_beat.kind, got.kind);
                        fail_count++;
                    end
                    if (got.status !== exp_beat.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_beat.status, got.status);
                        fail_count++;
                    end
                    if (got.last !== exp_beat.last) begin
                        $display("%0t: last expected %0d actual %0d", $time,
                                 exp_beat.last, got.last);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) execute_command(s_cmd, s_push_value);
        end
    end

endmodule

[tb/sv/tb_stack_machine_execute.sv]
`timescale 1ns / 100ps
module tb_stack_machine_execute;
    import smx_pkg::*;

    // This bound lies far above what a correct run needs, so it only trips
    // on a hang.
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_BEATS = 260;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_cmd = CMD_NOP;
    logic signed [DATA_W-1:0] s_push_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_out_value;
    logic [KIND_W-1:0]        m_out_kind;
    logic [STAT_W-1:0]        m_status;
    logic                     m_last;
    int                       pending;
    int                       errors;
    int                       cycle_count = 0;
    int                       idle_pct = 0;
    int                       stall_pct = 0;

    stack_machine_execute u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_push_value(s_push_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_value(m_out_value),
        .m_out_kind(m_out_kind), .m_status(m_status), .m_last(m_last)
    );

    stack_machine_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_push_value(s_push_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_value(m_out_value),
        .m_out_kind(m_out_kind), .m_status(m_status), .m_last(m_last),
        .pending(pending), .errors(errors)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // The receiver drops ready at random, at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Presents one command beat and returns at the edge where it is taken.
    // Idle cycles before the beat lower valid; back-to-back beats keep it high.
    // Ready is looked at on the falling edge, where it is settled for the
    // rising edge that follows.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_push_value <= value;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    // Operand values lean toward character codes 1 to 127 so that pstr walks far,
    // with zeros, extremes and full-width values mixed in.
    function automatic logic [DATA_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return $urandom_range(127, 1);
        if (sel < 48) return '0;
        if (sel < 52) return {1'b1, {(DATA_W-1){1'b0}}};
        if (sel < 56) return {1'b0, {(DATA_W-1){1'b1}}};
        if (sel < 60) return '1;
        if (sel < 64) return 32'd128;
        return $urandom;
    endfunction

    // Picks a command; push_pct steers the stack toward full or toward empty.
    function automatic logic [CMD_W-1:0] pick_command(int push_pct);
        if ($urandom_range(99) < push_pct) return CMD_PUSH;
        return CMD_W'($urandom_range(15, 1));
    endfunction

    initial begin
        int phase;
        int n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: errors on an empty stack, range limits of pchar,
        // division by zero, the wrapping divide and the unused code.
        send_command(CMD_POP, '0);
        send_command(CMD_PINT, '0);
        send_command(CMD_PCHAR, '0);
        send_command(CMD_ADD, '0);
        send_command(CMD_ROTL, '0);
        send_command(CMD_PALL, '0);
        send_command(CMD_PSTR, '0);
        send_command(CMD_PUSH, 32'h8000_0000);
        send_command(CMD_SWAP, '0);
        send_command(CMD_PCHAR, '0);
        send_command(CMD_PUSH, '1);
        send_command(CMD_DIV, '0);
        send_command(CMD_PUSH, '0);
        send_command(CMD_MOD, '0);
        send_command(CMD_PUSH, 32'd128);
        send_command(CMD_PCHAR, '0);
        send_command(CMD_PUSH, 32'd127);
        send_command(CMD_PCHAR, '0);
        send_command(CMD_PSTR, '0);
        send_command(CMD_MUL, '0);
        send_command(CMD_SUB, '0);
        send_command(CMD_ROTR, '0);
        send_command(CMD_PALL, '0);
        send_command(4'd15, 32'h7fff_ffff);

        // Hold off until the block has drained everything so far.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        // Random part in four phases of idle and stall rates. Each phase first fills
        // the stack hard and then drains it.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 79; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 79; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            for (n = 0; n < RANDOM_BEATS / 4; n++)
                send_command(pick_command(n < RANDOM_BEATS / 8 ? 75 : 25), pick_value());
        end

        s_valid <= 1'b0;
        stall_pct = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/smx_pkg.sv
design/smx_div.sv
design/smx_dpath.sv
design/smx_ctrl.sv
design/stack_machine_execute.sv
tb/sv/stack_machine_checker.sv
tb/sv/tb_stack_machine_execute.sv
